[rtl/core/pse_pkg.sv]
// Package for the Phong shading evaluator: pipeline stage map, stage record and stage logic.
`default_nettype none
package pse_pkg;

  localparam int unsigned LenBits   = 24;
  localparam int unsigned RlenBits  = 20;
  localparam int unsigned QuoBits   = 17;
  localparam int unsigned FracBits  = 16;

  localparam int unsigned S_PROD  = 1;
  localparam int unsigned S_SUM   = S_PROD + 1;
  localparam int unsigned S_SQ1   = S_SUM + 1;
  localparam int unsigned S_PRE1  = S_SQ1 + LenBits;
  localparam int unsigned S_DV1   = S_PRE1 + 1;
  localparam int unsigned S_QUO1  = S_DV1 + QuoBits;
  localparam int unsigned S_MUL1  = S_QUO1 + 1;
  localparam int unsigned S_REFL  = S_MUL1 + 1;
  localparam int unsigned S_MUL2  = S_REFL + 1;
  localparam int unsigned S_SUM2  = S_MUL2 + 1;
  localparam int unsigned S_SQ2   = S_SUM2 + 1;
  localparam int unsigned S_DEN   = S_SQ2 + RlenBits;
  localparam int unsigned S_PRE2  = S_DEN + 1;
  localparam int unsigned S_DV2   = S_PRE2 + 1;
  localparam int unsigned S_NORM  = S_DV2 + QuoBits;
  localparam int unsigned S_LOG   = S_NORM + 1;
  localparam int unsigned S_NLG   = S_LOG + FracBits;
  localparam int unsigned S_EXPT  = S_NLG + 1;
  localparam int unsigned S_EXP   = S_EXPT + 1;
  localparam int unsigned S_POW   = S_EXP + FracBits;
  localparam int unsigned S_SPEC  = S_POW + 1;
  localparam int unsigned S_OUT   = S_SPEC + 1;
  localparam int unsigned NumStages = S_OUT + 1;

  localparam logic [16:0] One = 17'd65536;
  localparam logic [17:0] Sat18 = 18'd262143;
  localparam logic [63:0] InvPi = 64'd20861;
  localparam logic [24:0] ShinBase = 25'd524288;
  localparam logic [8:0] ShinSlope = 9'd248;

  typedef enum logic [1:0] {
    PC_ZERO,
    PC_ONE,
    PC_CALC
  } pow_class_e;

  typedef struct packed {
    logic [2:0][15:0] l;
    logic [2:0][15:0] v;
    logic [2:0][15:0] n;
    logic [2:0][15:0] alb;
    logic [2:0][31:0] sq_l;
    logic [2:0][31:0] sq_v;
    logic [2:0][31:0] nl_p;
    logic [31:0]      sl;
    logic [31:0]      sv;
    logic [31:0]      dnl;
    logic [47:0]      rem_l;
    logic [47:0]      rem_v;
    logic [23:0]      len_l;
    logic [23:0]      len_v;
    logic             black;
    logic             ov_c;
    logic [40:0]      rem_c;
    logic [16:0]      q_c;
    logic [2:0]       lneg;
    logic [2:0][39:0] rem_h;
    logic [2:0][16:0] q_h;
    logic [16:0]      c;
    logic [2:0][17:0] lh;
    logic [2:0][33:0] cn;
    logic [2:0][32:0] ac;
    logic [2:0][19:0] r;
    logic [2:0][15:0] dif;
    logic [2:0][37:0] rsq;
    logic [2:0][35:0] rv;
    logic [39:0]      sr;
    logic [36:0]      drv;
    logic [39:0]      rem_r;
    logic [19:0]      len_r;
    logic [43:0]      den;
    logic             spec_en;
    logic             ov_s;
    logic [59:0]      rem_s;
    logic [16:0]      q_s;
    pow_class_e       cls;
    logic [4:0]       e;
    logic [30:0]      m;
    logic [15:0]      frac;
    logic [20:0]      nlg;
    logic [29:0]      t;
    logic [32:0]      acc;
    logic [16:0]      pow;
    logic [16:0]      spec;
    logic [2:0][17:0] shade;
  } pipe_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bitv;
    x = n;
    res = '0;
    for (int j = 31; j >= 0; j--) begin
      bitv = 64'd1 << (2 * j);
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  function automatic logic [16:1][31:0] exp_coef_fill();
    logic [63:0] c;
    logic [16:1][31:0] tb;
    c = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) begin
      c = isqrt64(c << 32);
      tb[k] = c[31:0];
    end
    return tb;
  endfunction

  localparam logic [16:1][31:0] ExpCoef = exp_coef_fill();

  function automatic pipe_t pse_step(input int unsigned s, input pipe_t p,
                                     input logic [15:0] spec_lvl, input logic [24:0] shin);
    pipe_t o;
    int unsigned b;
    int unsigned k;
    logic [63:0] trial;
    logic [63:0] w;
    logic [64:0] w65;
    logic signed [31:0] a32;
    logic signed [31:0] b32;
    logic signed [33:0] a34;
    logic signed [33:0] b34;
    logic signed [39:0] a40;
    logic signed [35:0] a36;
    logic signed [35:0] b36;
    logic [16:0] mag;
    logic [16:0] cosv;
    logic [3:0] pos;
    logic [31:0] sq30;
    logic [18:0] sum19;
    logic [33:0] s34;
    logic [41:0] s42;
    logic [36:0] d37;
    o = p;
    if (s == S_PROD) begin
      for (int i = 0; i < 3; i++) begin
        a32 = $signed({{16{p.l[i][15]}}, p.l[i]});
        b32 = $signed({{16{p.v[i][15]}}, p.v[i]});
        o.sq_l[i] = a32 * a32;
        o.sq_v[i] = b32 * b32;
        b32 = $signed({{16{p.n[i][15]}}, p.n[i]});
        o.nl_p[i] = a32 * b32;
      end
    end else if (s == S_SUM) begin
      s34 = {2'd0, p.sq_l[0]} + {2'd0, p.sq_l[1]} + {2'd0, p.sq_l[2]};
      o.sl = s34[31:0];
      s34 = {2'd0, p.sq_v[0]} + {2'd0, p.sq_v[1]} + {2'd0, p.sq_v[2]};
      o.sv = s34[31:0];
      o.dnl = p.nl_p[0] + p.nl_p[1] + p.nl_p[2];
      o.rem_l = {s34[31:0] == s34[31:0] ? o.sl : o.sl, 16'd0};
      o.rem_v = {o.sv, 16'd0};
      o.len_l = '0;
      o.len_v = '0;
    end else if (s >= S_SQ1 && s < S_PRE1) begin
      b = S_PRE1 - 1 - s;
      trial = ({40'd0, p.len_l} << (b + 1)) + (64'd1 << (2 * b));
      if ({16'd0, p.rem_l} >= trial) begin
        o.rem_l = p.rem_l - trial[47:0];
        o.len_l = p.len_l | (24'd1 << b);
      end
      trial = ({40'd0, p.len_v} << (b + 1)) + (64'd1 << (2 * b));
      if ({16'd0, p.rem_v} >= trial) begin
        o.rem_v = p.rem_v - trial[47:0];
        o.len_v = p.len_v | (24'd1 << b);
      end
    end else if (s == S_PRE1) begin
      o.black = ($signed(p.dnl) <= 0) || (p.len_l == '0);
      o.rem_c = {p.dnl[30:0], 10'd0};
      o.ov_c = {p.dnl[30:0], 10'd0} >= {p.len_l, 17'd0};
      o.q_c = '0;
      for (int i = 0; i < 3; i++) begin
        mag = p.l[i][15] ? (17'd0 - {1'b1, p.l[i]}) : {1'b0, p.l[i]};
        o.lneg[i] = p.l[i][15];
        o.rem_h[i] = {mag[15:0], 24'd0};
        o.q_h[i] = '0;
      end
    end else if (s >= S_DV1 && s < S_QUO1) begin
      b = S_QUO1 - 1 - s;
      trial = {40'd0, p.len_l} << b;
      if ({23'd0, p.rem_c} >= trial) begin
        o.rem_c = p.rem_c - trial[40:0];
        o.q_c[b] = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
        if ({24'd0, p.rem_h[i]} >= trial) begin
          o.rem_h[i] = p.rem_h[i] - trial[39:0];
          o.q_h[i][b] = 1'b1;
        end
      end
    end else if (s == S_QUO1) begin
      o.c = (p.ov_c || p.q_c > One) ? One : p.q_c;
      for (int i = 0; i < 3; i++) begin
        o.lh[i] = p.lneg[i] ? (18'd0 - {1'b0, p.q_h[i]}) : {1'b0, p.q_h[i]};
      end
    end else if (s == S_MUL1) begin
      for (int i = 0; i < 3; i++) begin
        a34 = $signed({17'd0, p.c});
        b34 = $signed({{18{p.n[i][15]}}, p.n[i]});
        s34 = a34 * b34;
        o.cn[i] = {s34[32:0], 1'b0};
        o.ac[i] = {17'd0, p.alb[i]} * {16'd0, p.c};
      end
    end else if (s == S_REFL) begin
      for (int i = 0; i < 3; i++) begin
        a34 = $signed(p.cn[i]) + (p.cn[i][33] ? 34'sd16383 : 34'sd0);
        a34 = a34 >>> 14;
        o.r[i] = a34[19:0] - {{2{p.lh[i][17]}}, p.lh[i]};
        w = {31'd0, p.ac[i]} * InvPi;
        o.dif[i] = w[47:32];
      end
    end else if (s == S_MUL2) begin
      for (int i = 0; i < 3; i++) begin
        a40 = $signed({{20{p.r[i][19]}}, p.r[i]});
        a40 = a40 * a40;
        o.rsq[i] = a40[37:0];
        a36 = $signed({{16{p.r[i][19]}}, p.r[i]});
        b36 = $signed({{20{p.v[i][15]}}, p.v[i]});
        o.rv[i] = a36 * b36;
      end
    end else if (s == S_SUM2) begin
      s42 = {4'd0, p.rsq[0]} + {4'd0, p.rsq[1]} + {4'd0, p.rsq[2]};
      o.sr = s42[39:0];
      d37 = {p.rv[0][35], p.rv[0]} + {p.rv[1][35], p.rv[1]} + {p.rv[2][35], p.rv[2]};
      o.drv = d37;
      o.rem_r = s42[39:0];
      o.len_r = '0;
    end else if (s >= S_SQ2 && s < S_DEN) begin
      b = S_DEN - 1 - s;
      trial = ({44'd0, p.len_r} << (b + 1)) + (64'd1 << (2 * b));
      if ({24'd0, p.rem_r} >= trial) begin
        o.rem_r = p.rem_r - trial[39:0];
        o.len_r = p.len_r | (20'd1 << b);
      end
    end else if (s == S_DEN) begin
      o.den = {24'd0, p.len_r} * {20'd0, p.len_v};
      o.spec_en = (p.len_r != '0) && (p.len_v != '0) && ($signed(p.drv) > 0);
    end else if (s == S_PRE2) begin
      o.rem_s = {p.drv[35:0], 24'd0};
      o.ov_s = {1'b0, p.drv[35:0], 24'd0} >= {p.den, 17'd0};
      o.q_s = '0;
    end else if (s >= S_DV2 && s < S_NORM) begin
      b = S_NORM - 1 - s;
      trial = {20'd0, p.den} << b;
      if ({4'd0, p.rem_s} >= trial) begin
        o.rem_s = p.rem_s - trial[59:0];
        o.q_s[b] = 1'b1;
      end
    end else if (s == S_NORM) begin
      if (!p.spec_en) begin
        cosv = '0;
      end else if (p.ov_s || p.q_s > One) begin
        cosv = One;
      end else begin
        cosv = p.q_s;
      end
      if (cosv == '0) begin
        o.cls = PC_ZERO;
      end else if (cosv >= One) begin
        o.cls = PC_ONE;
      end else begin
        o.cls = PC_CALC;
      end
      pos = '0;
      for (int j = 0; j < 16; j++) begin
        if (cosv[j]) begin
          pos = 4'(j);
        end
      end
      o.e = 5'd16 - {1'b0, pos};
      w = {48'd0, cosv[15:0]} << (14 + o.e);
      o.m = w[30:0];
      o.frac = '0;
    end else if (s >= S_LOG && s < S_NLG) begin
      w = {33'd0, p.m} * {33'd0, p.m};
      sq30 = w[61:30];
      if (sq30[31]) begin
        o.m = sq30[31:1];
        o.frac = {p.frac[14:0], 1'b1};
      end else begin
        o.m = sq30[30:0];
        o.frac = {p.frac[14:0], 1'b0};
      end
    end else if (s == S_NLG) begin
      o.nlg = {p.e, 16'd0} - {5'd0, p.frac};
    end else if (s == S_EXPT) begin
      w = {39'd0, shin} * {43'd0, p.nlg};
      o.t = w[45:16];
      if (p.cls == PC_CALC && w[45:16] >= 30'(17 << 16)) begin
        o.cls = PC_ZERO;
      end
      o.acc = 33'h1_0000_0000;
    end else if (s >= S_EXP && s < S_POW) begin
      k = s - S_EXP + 1;
      if (p.t[16 - k]) begin
        w65 = {32'd0, p.acc} * {33'd0, ExpCoef[k]};
        o.acc = w65[64:32];
      end
    end else if (s == S_POW) begin
      w = {31'd0, p.acc} >> (16 + p.t[20:16]);
      if (p.cls == PC_ZERO) begin
        o.pow = '0;
      end else if (p.cls == PC_ONE) begin
        o.pow = One;
      end else begin
        o.pow = w[16:0];
      end
    end else if (s == S_SPEC) begin
      w = {47'd0, p.pow} * {48'd0, spec_lvl};
      o.spec = w[32:16];
    end else if (s == S_OUT) begin
      for (int i = 0; i < 3; i++) begin
        sum19 = {3'd0, p.dif[i]} + {2'd0, p.spec};
        if (p.black) begin
          o.shade[i] = '0;
        end else if (sum19 > {1'b0, Sat18}) begin
          o.shade[i] = Sat18;
        end else begin
          o.shade[i] = sum19[17:0];
        end
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

[rtl/core/pse_if.sv]
// Channel interfaces of the Phong shading evaluator: input items, results and configuration.
`default_nettype none
interface pse_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] light_x;
  logic signed [15:0] light_y;
  logic signed [15:0] light_z;
  logic signed [15:0] view_x;
  logic signed [15:0] view_y;
  logic signed [15:0] view_z;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic [15:0]        albedo_red;
  logic [15:0]        albedo_green;
  logic [15:0]        albedo_blue;

  modport source (output valid, light_x, light_y, light_z, view_x, view_y, view_z,
                  normal_x, normal_y, normal_z, albedo_red, albedo_green, albedo_blue,
                  input ready);
  modport sink (input valid, light_x, light_y, light_z, view_x, view_y, view_z,
                normal_x, normal_y, normal_z, albedo_red, albedo_green, albedo_blue,
                output ready);
endinterface

interface pse_out_if;
  logic        valid;
  logic        ready;
  logic [17:0] shade_red;
  logic [17:0] shade_green;
  logic [17:0] shade_blue;

  modport source (output valid, shade_red, shade_green, shade_blue, input ready);
  modport sink (input valid, shade_red, shade_green, shade_blue, output ready);
endinterface

interface pse_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] spec_level;

  modport source (output valid, spec_level, input ready);
  modport sink (input valid, spec_level, output ready);
endinterface
`default_nettype wire

[rtl/core/phong_shading_evaluate_top.sv]
// Top level of the Phong shading evaluator: a fully pipelined shading datapath.
// The block shades one item per clock. An item on in_i carries the light and view
// directions, a unit normal in Q1.14 and an albedo color in Q0.16. Each item yields
// exactly one result on out_o, the diffuse plus specular color in Q2.16, saturated.
// The specular level is written through cfg_i, which is always ready; write it only
// while no item is in flight.
// The pipeline depth is set by the bit-serial stages of the two square-root chains,
// the two dividers, the log2 squaring chain and the exp2 chain.
// Throughput is one item per cycle while the receiver takes results.
// When the receiver stalls with a result waiting, the whole pipeline holds and in_i
// ready drops in the same cycle; empty slots do not close up during the stall, and
// input resumes in the cycle in which the receiver takes the waiting result.
// Reset empties the pipeline and sets the specular level to zero.
`default_nettype none
module phong_shading_evaluate_top import pse_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pse_in_if.sink     in_i,
  pse_cfg_if.sink    cfg_i,
  pse_out_if.source  out_o
);

  logic                  adv;
  logic [NumStages-1:0]  v_q;
  pipe_t                 pipe_d [NumStages];
  pipe_t                 pipe_q [NumStages];
  logic [15:0]           spec_q;
  logic [24:0]           shin_q;
  logic [24:0]           shin_d;

  assign adv          = !v_q[NumStages-1] || out_o.ready;
  assign in_i.ready   = adv;
  assign cfg_i.ready  = 1'b1;
  assign shin_d       = ShinBase + 25'({16'd0, ShinSlope} * {9'd0, cfg_i.spec_level});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spec_q <= '0;
      shin_q <= ShinBase;
    end else if (cfg_i.valid) begin
      spec_q <= cfg_i.spec_level;
      shin_q <= shin_d;
    end
  end

  always_comb begin
    pipe_d[0]     = '0;
    pipe_d[0].l   = {in_i.light_z, in_i.light_y, in_i.light_x};
    pipe_d[0].v   = {in_i.view_z, in_i.view_y, in_i.view_x};
    pipe_d[0].n   = {in_i.normal_z, in_i.normal_y, in_i.normal_x};
    pipe_d[0].alb = {in_i.albedo_blue, in_i.albedo_green, in_i.albedo_red};
  end

  for (genvar g = 1; g < NumStages; g++) begin : g_stage
    assign pipe_d[g] = pse_step(g, pipe_q[g-1], spec_q, shin_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NumStages-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pipe_q <= pipe_d;
    end
  end

  assign out_o.valid       = v_q[NumStages-1];
  assign out_o.shade_red   = pipe_q[NumStages-1].shade[0];
  assign out_o.shade_green = pipe_q[NumStages-1].shade[1];
  assign out_o.shade_blue  = pipe_q[NumStages-1].shade[2];

`ifndef SYNTH
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NumStages-1] && !out_o.ready) |=> (v_q[NumStages-1] && $stable(v_q)))
    else $error("pipeline moved while the output was blocked");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v_q[0])
    else $error("accepted item did not enter the pipeline");

  a_cos_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[S_QUO1] |-> (pipe_q[S_QUO1].c <= One))
    else $error("diffuse cosine above one");

  a_spec_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[S_SPEC] |-> (pipe_q[S_SPEC].spec <= One))
    else $error("specular term above one");
`endif

endmodule
`default_nettype wire

[bench/tb_phong_shading_evaluate_top.sv]
// Self-checking testbench for the Phong shading evaluator with an in-bench shading predictor.
`timescale 1ns / 1ps
module tb_phong_shading_evaluate_top;
  import pse_pkg::*;

  typedef struct {
    shortint     l[3];
    shortint     v[3];
    shortint     n[3];
    logic [15:0] a[3];
  } shade_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pse_in_if  in_if ();
  pse_cfg_if cfg_if ();
  pse_out_if out_if ();

  phong_shading_evaluate_top dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  always #2 clk = ~clk;

  shade_item_t      pending_items[$];
  logic [2:0][17:0] expected_shades[$];
  logic [15:0]      spec_copy = '0;
  logic             item_taken = 1'b0;
  logic             shade_taken = 1'b0;
  int               shades_seen = 0;
  int               mismatches = 0;
  bit               in_burst = 1'b0;
  bit               out_burst = 1'b0;

  function automatic longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned root = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Raises a Q16 cosine to a Q8.16 power through a log2 and an exp2 in fixed point.
  function automatic longint unsigned cos_power(longint unsigned x, longint unsigned shin);
    longint unsigned m, ex, frac, t, acc, coef;
    if (x == 0) return 0;
    if (x >= 65536) return 65536;
    m = x << 14;
    ex = 0;
    frac = 0;
    while (m < (64'd1 << 30)) begin
      m <<= 1;
      ex++;
    end
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= (64'd2 << 30)) begin
        m >>= 1;
        frac |= 1;
      end
    end
    t = (shin * ((ex << 16) - frac)) >> 16;
    if (t >= (64'd17 << 16)) return 0;
    acc = 64'd1 << 32;
    coef = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) begin
      coef = sqrt_floor(coef << 32);
      if ((t >> (16 - k)) & 1) acc = (acc * coef) >> 32;
    end
    return acc >> (16 + (t >> 16));
  endfunction

  function automatic logic [2:0][17:0] predict_shade(shade_item_t it, logic [15:0] sp);
    longint L[3], V[3], N[3], R[3];
    longint lh, dnl, drv;
    longint unsigned sl, sv, sr, lenl, lenv, lenr, c, cosv, spec, d, s, udrv;
    logic [2:0][17:0] res;
    dnl = 0;
    drv = 0;
    sl = 0;
    sv = 0;
    sr = 0;
    spec = 0;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      L[i] = it.l[i];
      V[i] = it.v[i];
      N[i] = it.n[i];
      sl += L[i] * L[i];
      sv += V[i] * V[i];
      dnl += N[i] * L[i];
    end
    lenl = sqrt_floor(sl << 16);
    if (lenl == 0 || dnl <= 0) return res;
    c = (longint'(dnl) << 10) / lenl;
    if (c > 65536) c = 65536;
    for (int i = 0; i < 3; i++) begin
      lh = (L[i] * 16777216) / longint'(lenl);
      R[i] = (2 * longint'(c) * N[i]) / 16384 - lh;
      sr += R[i] * R[i];
      drv += R[i] * V[i];
    end
    lenr = sqrt_floor(sr);
    lenv = sqrt_floor(sv << 16);
    if (lenr != 0 && lenv != 0 && drv > 0) begin
      udrv = drv;
      cosv = (udrv << 24) / (lenr * lenv);
      if (cosv > 65536) cosv = 65536;
      spec = (cos_power(cosv, (64'd8 << 16) + 248 * longint'(sp)) * sp) >> 16;
    end
    for (int i = 0; i < 3; i++) begin
      d = (longint'(it.a[i]) * c * 20861) >> 32;
      s = d + spec;
      res[i] = (s > 262143) ? 18'd262143 : s[17:0];
    end
    return res;
  endfunction

  function automatic shortint signed_draw(int lim);
    return shortint'(int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  // Mostly items whose view lies near the mirror direction, so the specular power is exercised.
  function automatic shade_item_t random_item();
    shade_item_t it;
    int kind, ax, jit;
    kind = int'($urandom_range(0, 9));
    for (int i = 0; i < 3; i++) begin
      it.l[i] = shortint'($urandom());
      it.v[i] = shortint'($urandom());
      it.n[i] = signed_draw(16384);
      it.a[i] = 16'($urandom());
    end
    if (kind < 6) begin
      ax = int'($urandom_range(0, 2));
      jit = (kind < 3) ? int'($urandom_range(0, 40)) : int'($urandom_range(0, 3000));
      for (int i = 0; i < 3; i++) begin
        it.n[i] = 0;
        it.l[i] = signed_draw(30000);
      end
      it.n[ax] = ($urandom_range(0, 1) != 0) ? shortint'(16384) : shortint'(-16384);
      it.l[ax] = (it.n[ax] > 0) ? shortint'($urandom_range(1, 30000))
                                : shortint'(-int'($urandom_range(1, 30000)));
      for (int i = 0; i < 3; i++) begin
        it.v[i] = (i == ax) ? it.l[i] : -it.l[i];
        it.v[i] += signed_draw(jit);
      end
    end
    return it;
  endfunction

  function automatic shade_item_t make_item(shortint lx, shortint ly, shortint lz,
                                            shortint vx, shortint vy, shortint vz,
                                            shortint nx, shortint ny, shortint nz,
                                            logic [15:0] ar, logic [15:0] ag,
                                            logic [15:0] ab);
    shade_item_t it;
    it.l = '{lx, ly, lz};
    it.v = '{vx, vy, vz};
    it.n = '{nx, ny, nz};
    it.a = '{ar, ag, ab};
    return it;
  endfunction

  always @(posedge clk) begin
    shade_item_t it;
    logic [2:0][17:0] exp_shade;
    if (cfg_if.valid && cfg_if.ready) spec_copy = cfg_if.spec_level;
    item_taken <= in_if.valid && in_if.ready;
    shade_taken <= out_if.valid && out_if.ready;
    if (in_if.valid && in_if.ready) begin
      it.l = '{in_if.light_x, in_if.light_y, in_if.light_z};
      it.v = '{in_if.view_x, in_if.view_y, in_if.view_z};
      it.n = '{in_if.normal_x, in_if.normal_y, in_if.normal_z};
      it.a = '{in_if.albedo_red, in_if.albedo_green, in_if.albedo_blue};
      expected_shades.push_back(predict_shade(it, spec_copy));
    end
    if (out_if.valid && out_if.ready) begin
      shades_seen++;
      if (expected_shades.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h %h %h", out_if.shade_red,
                                       out_if.shade_green, out_if.shade_blue);
      end else begin
        exp_shade = expected_shades.pop_front();
        if (exp_shade != {out_if.shade_blue, out_if.shade_green, out_if.shade_red}) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Result %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     shades_seen, exp_shade[0], exp_shade[1], exp_shade[2],
                     out_if.shade_red, out_if.shade_green, out_if.shade_blue);
          end
        end
      end
    end
  end

  int send_gap = 0;
  always @(negedge clk) begin
    shade_item_t it;
    if (rst_n && (!in_if.valid || item_taken)) begin
      if (item_taken) begin
        if ($urandom_range(0, 29) == 0) in_burst = !in_burst;
        send_gap = in_burst ? 0 : int'($urandom_range(0, 19));
      end
      if (send_gap == 0 && pending_items.size() != 0) begin
        it = pending_items.pop_front();
        in_if.light_x <= it.l[0];
        in_if.light_y <= it.l[1];
        in_if.light_z <= it.l[2];
        in_if.view_x <= it.v[0];
        in_if.view_y <= it.v[1];
        in_if.view_z <= it.v[2];
        in_if.normal_x <= it.n[0];
        in_if.normal_y <= it.n[1];
        in_if.normal_z <= it.n[2];
        in_if.albedo_red <= it.a[0];
        in_if.albedo_green <= it.a[1];
        in_if.albedo_blue <= it.a[2];
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end
    end
  end

  int take_stall = 0;
  int hold_off = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (shade_taken) begin
        if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
        take_stall = out_burst ? 0 : int'($urandom_range(0, 19));
        if (shades_seen == 300) hold_off = 600;
      end
      if (hold_off > 0) begin
        hold_off--;
        out_if.ready <= 1'b0;
      end else if (out_if.ready && !shade_taken) begin
        out_if.ready <= 1'b1;
      end else if (take_stall > 0) begin
        take_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic write_spec(logic [15:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.spec_level <= value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain_all();
    while (pending_items.size() != 0 || in_if.valid || expected_shades.size() != 0)
      @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  task automatic run_phase(logic [15:0] spec_value, int count);
    write_spec(spec_value);
    for (int i = 0; i < count; i++) pending_items.push_back(random_item());
    drain_all();
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.light_x = '0;
    in_if.light_y = '0;
    in_if.light_z = '0;
    in_if.view_x = '0;
    in_if.view_y = '0;
    in_if.view_z = '0;
    in_if.normal_x = '0;
    in_if.normal_y = '0;
    in_if.normal_z = '0;
    in_if.albedo_red = '0;
    in_if.albedo_green = '0;
    in_if.albedo_blue = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.spec_level = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed items first, with the reset specular level and then full specular.
    pending_items.push_back(make_item(0, 0, 1000, 0, 0, 1000, 0, 0, 16384, 16'hffff,
                                      16'hffff, 16'hffff));
    pending_items.push_back(make_item(0, 0, 0, 5, 5, 5, 0, 0, 16384, 16'hffff, 1, 2));
    pending_items.push_back(make_item(0, 0, -500, 0, 0, 1, 0, 0, 16384, 100, 200, 300));
    pending_items.push_back(make_item(100, 0, 0, 0, 0, 0, 16384, 0, 0, 16'hffff, 0, 1234));
    pending_items.push_back(make_item(-32768, -32768, -32768, 32767, 32767, 32767,
                                      -16384, -16384, -16384, 16'hffff, 16'hffff, 16'hffff));
    pending_items.push_back(make_item(32767, 32767, 32767, -32768, -32768, -32768,
                                      16384, 16384, 16384, 0, 0, 0));
    pending_items.push_back(make_item(0, 1, 0, 1, 0, 0, 0, 16384, 0, 40000, 50000, 60000));
    pending_items.push_back(make_item(1, 1, 0, -1, 1, 0, 0, 16384, 0, 16'hffff, 0, 0));
    pending_items.push_back(make_item(0, 300, 300, 0, 300, -300, 0, 0, 16384, 9000, 9000,
                                      9000));
    pending_items.push_back(make_item(0, 0, 1, 0, 0, -1, 0, 0, 16384, 16'hffff, 16'hffff,
                                      16'hffff));
    drain_all();
    write_spec(16'hffff);
    pending_items.push_back(make_item(0, 0, 1000, 0, 0, 1000, 0, 0, 16384, 16'hffff,
                                      16'hffff, 16'hffff));
    pending_items.push_back(make_item(3, 0, 1000, -3, 0, 1000, 0, 0, 16384, 16'hffff,
                                      16'hffff, 16'hffff));
    pending_items.push_back(make_item(200, 0, 1000, -200, 0, 1000, 0, 0, 16384, 1, 2, 3));
    pending_items.push_back(make_item(10, 20, 30, 0, 0, 0, 0, 0, 16384, 500, 500, 500));
    pending_items.push_back(make_item(32767, 0, 32767, -32768, 0, 32767, 0, 0, 16384,
                                      16'hffff, 16'hffff, 16'hffff));
    drain_all();

    run_phase(16'h0000, 250);
    run_phase(16'hffff, 350);
    run_phase(16'h0001, 200);
    run_phase(16'h8000, 250);
    run_phase(16'($urandom()), 250);
    run_phase(16'($urandom_range(0, 4000)), 200);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
